@@ rtl/core/binned_statistics_accumulator_core_assert.svh @@
// assertion macros for the binned statistics core
`ifndef BINNED_STATISTICS_ACCUMULATOR_CORE_ASSERT_SVH
`define BINNED_STATISTICS_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication, checked after reset
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked after reset
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bsa_pkg.sv @@
// shared codes and constants for the binned statistics core
package bsa_pkg;

    // operation codes
    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic CFG_X_BINS = 1'b0;
    localparam logic CFG_Y_BINS = 1'b1;

    localparam logic [6:0] CFG_RESET = 7'd64;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    localparam int ROOT_W = 16;

    typedef enum logic [8:0] {
        S_RUN   = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_MULQ  = 9'b000000100,
        S_MULS  = 9'b000001000,
        S_DIV1  = 9'b000010000,
        S_DIV2  = 9'b000100000,
        S_DIVM  = 9'b001000000,
        S_SQRT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

endpackage

@@ rtl/core/binned_statistics_accumulator_core.sv @@
// binned statistics core: per-bin count, sum, sum of squares, min and max in one memory
//
// input channel (in_valid / in_stall) carries operation, x_bin, y_bin, sample_value;
// an item is taken when in_valid is high and in_stall is low
// accumulate items stream at one per cycle while in_stall is low: the address is formed
// and the bin word read at accept, the next cycle modifies it and writes it back; a
// one-entry forward register covers back-to-back items to the same bin
// a read item produces one result on the output channel (out_valid / out_stall);
// mean and std come from one shared bit-serial unit: a shift-add multiplier for
// sqr*count and sum^2, a restoring divider run three times, and a 16-step square root;
// a read steps through S_MULQ, S_MULS, S_DIV1, S_DIV2, S_DIVM and S_SQRT to S_DONE before
// out_valid rises; out of range or empty bins go from accept straight to S_DONE
// a clear item sweeps the memory one bin per cycle, and the next item is taken once
// all MAX_X_BINS*MAX_Y_BINS bins hold the empty word
// reset runs the same sweep with in_stall high, the first item is taken after it ends;
// configuration writes are taken at any time, cfg_ready high
// when the receiver stalls, the result holds in the output register and the block
// keeps accepting items; a further read is computed, then holds in_stall high until
// the register frees
module binned_statistics_accumulator_core
    import bsa_pkg::*;
#(
    parameter int MAX_X_BINS = 64,
    parameter int MAX_Y_BINS = 64,
    parameter int COUNT_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [5:0]          x_bin,
    input  logic [5:0]          y_bin,
    input  logic signed [15:0]  sample_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [23:0]         bin_count,
    output logic signed [39:0]  bin_sum,
    output logic signed [15:0]  bin_mean,
    output logic [15:0]         bin_std,
    output logic signed [15:0]  bin_min,
    output logic signed [15:0]  bin_max,
    output logic                bin_empty,
    output logic                bin_out_of_range,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data
);

    localparam int DEPTH  = MAX_X_BINS * MAX_Y_BINS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = COUNT_BITS + 16;
    localparam int SQ_W   = COUNT_BITS + 31;
    localparam int DW     = SQ_W + COUNT_BITS;
    localparam int CNT_W  = $clog2(DW + 1);

    // one memory word holds a whole bin
    typedef struct packed {
        logic [COUNT_BITS-1:0]    count;
        logic signed [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]          sq;
        logic signed [15:0]       vmin;
        logic signed [15:0]       vmax;
    } bin_word_t;

    localparam bin_word_t EMPTY_WORD = '{
        count: '0, sum: '0, sq: '0, vmin: SAMPLE_MAX, vmax: SAMPLE_MIN
    };

    // configuration
    logic [6:0] x_bins_reg;
    logic [6:0] y_bins_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_bins_reg <= CFG_RESET;
            y_bins_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_X_BINS: x_bins_reg <= cfg_data;
                CFG_Y_BINS: y_bins_reg <= cfg_data;
                default:    x_bins_reg <= x_bins_reg;
            endcase
        end
    end

    // front end: range check and flat address at accept
    logic [31:0]       xn_eff;
    logic [31:0]       yn_eff;
    logic              in_range;
    logic [31:0]       flat_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              in_accept;
    state_t            state_reg;
    state_t            state_next;

    assign xn_eff = (32'(x_bins_reg) > 32'(MAX_X_BINS)) ? 32'(MAX_X_BINS) : 32'(x_bins_reg);
    assign yn_eff = (32'(y_bins_reg) > 32'(MAX_Y_BINS)) ? 32'(MAX_Y_BINS) : 32'(y_bins_reg);
    assign in_range = (32'(x_bin) < xn_eff) && (32'(y_bin) < yn_eff);
    assign flat_addr = 32'(y_bin) + yn_eff * 32'(x_bin);
    assign rd_addr = in_range ? ADDR_W'(flat_addr) : '0;

    // stage 1 registers: item whose bin word is being read
    logic               s1_valid_reg;
    logic [1:0]         s1_op_reg;
    logic               s1_inside_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic signed [15:0] s1_v_reg;
    logic [31:0]        s1_v2_reg;

    assign in_stall = (state_reg != S_RUN)
                   || (s1_valid_reg && ((s1_op_reg == OP_READ) || (s1_op_reg == OP_CLEAR)));
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= operation;
            s1_inside_reg <= in_range;
            s1_addr_reg   <= rd_addr;
            s1_v_reg      <= sample_value;
            s1_v2_reg     <= 32'(32'(sample_value) * 32'(sample_value));
        end
    end

    // bin memory, one read and one write port, registered read
    bin_word_t         mem [DEPTH];
    bin_word_t         rd_word_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    bin_word_t         mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // forward the last accumulate write: the read taken at the edge that wrote it missed it
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    bin_word_t         fwd_word_reg;
    bin_word_t         base_word;
    bin_word_t         acc_word;
    logic              acc_we;

    assign base_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_word_reg
                                                                        : rd_word_reg;

    always_comb
    begin
        acc_word       = base_word;
        acc_word.count = base_word.count + 1'b1;
        acc_word.sum   = base_word.sum + SUM_W'(s1_v_reg);
        acc_word.sq    = base_word.sq + SQ_W'(s1_v2_reg);
        if (s1_v_reg < base_word.vmin)
        begin
            acc_word.vmin = s1_v_reg;
        end
        if (s1_v_reg > base_word.vmax)
        begin
            acc_word.vmax = s1_v_reg;
        end
    end

    // saturated bins drop the sample whole
    assign acc_we = s1_valid_reg && (s1_op_reg == OP_ACC) && s1_inside_reg
                 && !(&base_word.count);

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    assign mem_we    = acc_we || (state_reg == S_CLEAR);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : s1_addr_reg;
    assign mem_wdata = (state_reg == S_CLEAR) ? EMPTY_WORD : acc_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= acc_we;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= s1_addr_reg;
        fwd_word_reg <= acc_word;
    end

    // read statistics: serial multiply, divide and square root
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DW-1:0]            acc_reg, acc_next;
    logic [DW-1:0]            mcand_reg, mcand_next;
    logic [SUM_W-1:0]         mplier_reg, mplier_next;
    logic [DW-1:0]            div_num_reg, div_num_next;
    logic [COUNT_BITS-1:0]    div_rem_reg, div_rem_next;
    logic [COUNT_BITS-1:0]    st_n_reg, st_n_next;
    logic signed [SUM_W-1:0]  st_s_reg, st_s_next;
    logic signed [15:0]       st_min_reg, st_min_next;
    logic signed [15:0]       st_max_reg, st_max_next;
    logic [SUM_W-1:0]         mag_reg, mag_next;
    logic                     st_empty_reg, st_empty_next;
    logic                     st_oor_reg, st_oor_next;
    logic [15:0]              mean_reg, mean_next;
    logic [31:0]              sqrt_in_reg, sqrt_in_next;
    logic                     sqrt_sat_reg, sqrt_sat_next;
    logic [ROOT_W-1:0]        root_reg, root_next;

    // divider step
    logic [COUNT_BITS:0]      div_trial;
    logic                     div_ge;
    logic [COUNT_BITS-1:0]    div_rem_step;
    logic [DW-1:0]            div_num_step;

    assign div_trial    = {div_rem_reg, div_num_reg[DW-1]};
    assign div_ge       = div_trial >= {1'b0, st_n_reg};
    assign div_rem_step = div_ge ? COUNT_BITS'(div_trial - {1'b0, st_n_reg})
                                 : COUNT_BITS'(div_trial);
    assign div_num_step = {div_num_reg[DW-2:0], div_ge};

    // square root step
    logic [ROOT_W-1:0] root_trial;
    logic [31:0]       root_sq;

    assign root_trial = root_reg | (ROOT_W'(1) << cnt_reg[3:0]);
    assign root_sq    = 32'(root_trial) * 32'(root_trial);

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic [23:0]         bin_count_reg;
    logic signed [39:0]  bin_sum_reg;
    logic signed [15:0]  bin_mean_reg;
    logic [15:0]         bin_std_reg;
    logic signed [15:0]  bin_min_reg;
    logic signed [15:0]  bin_max_reg;
    logic                bin_empty_reg;
    logic                bin_oor_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        div_num_next  = div_num_reg;
        div_rem_next  = div_rem_reg;
        st_n_next     = st_n_reg;
        st_s_next     = st_s_reg;
        st_min_next   = st_min_reg;
        st_max_next   = st_max_reg;
        mag_next      = mag_reg;
        st_empty_next = st_empty_reg;
        st_oor_next   = st_oor_reg;
        mean_next     = mean_reg;
        sqrt_in_next  = sqrt_in_reg;
        sqrt_sat_next = sqrt_sat_reg;
        root_next     = root_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            S_RUN:
            begin
                if (s1_valid_reg && (s1_op_reg == OP_READ))
                begin
                    st_n_next     = base_word.count;
                    st_s_next     = base_word.sum;
                    st_min_next   = base_word.vmin;
                    st_max_next   = base_word.vmax;
                    mag_next      = base_word.sum[SUM_W-1] ? SUM_W'(-base_word.sum)
                                                           : SUM_W'(base_word.sum);
                    st_oor_next   = !s1_inside_reg;
                    st_empty_next = !s1_inside_reg || (base_word.count == '0);
                    acc_next      = '0;
                    mcand_next    = DW'(base_word.sq);
                    mplier_next   = SUM_W'(base_word.count);
                    cnt_next      = CNT_W'(COUNT_BITS - 1);
                    if (!s1_inside_reg || (base_word.count == '0))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MULQ;
                    end
                end
                else if (s1_valid_reg && (s1_op_reg == OP_CLEAR))
                begin
                    clr_addr_next = '0;
                    state_next    = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_RUN;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_MULQ:
            begin
                // sqr * count
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    mcand_next  = DW'(mag_reg);
                    mplier_next = mag_reg;
                    cnt_next    = CNT_W'(SUM_W - 1);
                    state_next  = S_MULS;
                end
            end
            S_MULS:
            begin
                // minus sum^2, never goes negative
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg - mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    div_num_next = acc_next;
                    div_rem_next = '0;
                    cnt_next     = CNT_W'(DW - 1);
                    state_next   = S_DIV1;
                end
            end
            S_DIV1:
            begin
                div_num_next = div_num_step;
                div_rem_next = div_rem_step;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    div_rem_next = '0;
                    cnt_next     = CNT_W'(DW - 1);
                    state_next   = S_DIV2;
                end
            end
            S_DIV2:
            begin
                div_num_next = div_num_step;
                div_rem_next = div_rem_step;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    sqrt_in_next  = div_num_step[31:0];
                    sqrt_sat_next = |div_num_step[DW-1:32];
                    div_num_next  = DW'(mag_reg);
                    div_rem_next  = '0;
                    cnt_next      = CNT_W'(DW - 1);
                    state_next    = S_DIVM;
                end
            end
            S_DIVM:
            begin
                // |sum| / count, sign put back after
                div_num_next = div_num_step;
                div_rem_next = div_rem_step;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    mean_next  = st_s_reg[SUM_W-1] ? 16'(-div_num_step) : 16'(div_num_step);
                    root_next  = '0;
                    cnt_next   = CNT_W'(ROOT_W - 1);
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (root_sq <= sqrt_in_reg)
                begin
                    root_next = root_trial;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        div_num_reg  <= div_num_next;
        div_rem_reg  <= div_rem_next;
        st_n_reg     <= st_n_next;
        st_s_reg     <= st_s_next;
        st_min_reg   <= st_min_next;
        st_max_reg   <= st_max_next;
        mag_reg      <= mag_next;
        st_empty_reg <= st_empty_next;
        st_oor_reg   <= st_oor_next;
        mean_reg     <= mean_next;
        sqrt_in_reg  <= sqrt_in_next;
        sqrt_sat_reg <= sqrt_sat_next;
        root_reg     <= root_next;
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            bin_empty_reg <= st_empty_reg;
            bin_oor_reg   <= st_oor_reg;
            if (st_empty_reg)
            begin
                // empty or outside the grid: all statistics read zero
                bin_count_reg <= '0;
                bin_sum_reg   <= '0;
                bin_mean_reg  <= '0;
                bin_std_reg   <= '0;
                bin_min_reg   <= '0;
                bin_max_reg   <= '0;
            end
            else
            begin
                bin_count_reg <= 24'(st_n_reg);
                bin_sum_reg   <= 40'(st_s_reg);
                bin_mean_reg  <= mean_reg;
                bin_std_reg   <= sqrt_sat_reg ? 16'hFFFF : root_reg;
                bin_min_reg   <= st_min_reg;
                bin_max_reg   <= st_max_reg;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign bin_count        = bin_count_reg;
    assign bin_sum          = bin_sum_reg;
    assign bin_mean         = bin_mean_reg;
    assign bin_std          = bin_std_reg;
    assign bin_min          = bin_min_reg;
    assign bin_max          = bin_max_reg;
    assign bin_empty        = bin_empty_reg;
    assign bin_out_of_range = bin_oor_reg;

`include "binned_statistics_accumulator_core_assert.svh"

    `BSA_ASSERT_NEXT(a_read_leaves_run, s1_valid_reg && (s1_op_reg == OP_READ), state_reg != S_RUN, "read item did not start the statistics sequence")
    `BSA_ASSERT_NOW(a_acc_count_nonzero, acc_we, acc_word.count != '0, "accumulate write with zero count")
    `BSA_ASSERT_NOW(a_root_bound, state_reg == S_SQRT, (32'(root_reg) * 32'(root_reg)) <= sqrt_in_reg, "square root overshoot")
    `BSA_ASSERT_NOW(a_div_rem, (state_reg == S_DIV1) || (state_reg == S_DIV2) || (state_reg == S_DIVM), div_rem_reg < st_n_reg, "divider remainder not below count")
    `BSA_ASSERT_NOW(a_clear_blocks, state_reg == S_CLEAR, in_stall, "item taken during clear sweep")

endmodule
